>>> hw/rtl/cdsc_pkg.sv
package cdsc_pkg;

	// field widths fixed by the stream format
	localparam int DAY_W    = 5;
	localparam int MONTH_W  = 4;
	localparam int YEAR_W   = 14;
	localparam int DCNT_W   = 22;
	localparam int MCNT_W   = 17;
	localparam int YCNT_W   = 14;

	// action codes
	localparam logic ACT_DIFF = 1'b0;
	localparam logic ACT_SUB  = 1'b1;

	// calendar constants
	localparam logic [MONTH_W-1:0] MON_JAN = 4'd1;
	localparam logic [MONTH_W-1:0] MON_FEB = 4'd2;
	localparam logic [MONTH_W-1:0] MON_APR = 4'd4;
	localparam logic [MONTH_W-1:0] MON_JUN = 4'd6;
	localparam logic [MONTH_W-1:0] MON_SEP = 4'd9;
	localparam logic [MONTH_W-1:0] MON_NOV = 4'd11;
	localparam logic [MONTH_W-1:0] MON_DEC = 4'd12;
	localparam logic [DAY_W-1:0]   DAY_ONE = 5'd1;

	// divisibility by 25: multiply by the inverse of 25 mod 2^16, then
	// the product is small exactly for multiples of 25
	localparam logic [15:0] INV25     = 16'd23593;
	localparam logic [15:0] DIV25_MAX = 16'd2621;

	typedef logic [YEAR_W-1:0] year_t;

	// year in the high bits so a plain compare orders dates
	typedef struct packed {
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
	} date_t;

	// one classified request from front to back
	typedef struct packed {
		logic              act;
		logic              bad;
		date_t             first;
		date_t             last;
		logic [DCNT_W-1:0] days_back;
	} cmd_t;

	// one finished result
	typedef struct packed {
		logic [DCNT_W-1:0]  day_count;
		logic [MCNT_W-1:0]  month_crossings;
		logic [YCNT_W-1:0]  year_crossings;
		logic [DAY_W-1:0]   result_day;
		logic [MONTH_W-1:0] result_month;
		logic [YEAR_W-1:0]  result_year;
		logic               underflow;
		logic               bad_date;
	} result_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_RUN,
		BK_DONE
	} back_state_t;

	// Gregorian leap test: /4 and not /100, or /400
	function automatic logic is_leap(input logic [YEAR_W-1:0] y);
		logic [15:0] y16;
		logic [31:0] prod;
		logic        div25;
		y16   = 16'(y);
		prod  = 32'(y16) * 32'(INV25);
		div25 = (prod[15:0] <= DIV25_MAX);
		return (y16[1:0] == 2'd0) && (!div25 || (y16[3:0] == 4'd0));
	endfunction

	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
			input logic leap);
		logic [DAY_W-1:0] len;
		case (m)
			MON_FEB: len = leap ? 5'd29 : 5'd28;
			MON_APR, MON_JUN, MON_SEP, MON_NOV: len = 5'd30;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

>>> hw/rtl/cdsc_front.sv
module cdsc_front #(
	parameter int YEAR_BITS = 14
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              action,
	input  cdsc_pkg::date_t                   start_date,
	input  cdsc_pkg::date_t                   target_date,
	input  logic [cdsc_pkg::DCNT_W-1:0]       days_back,
	output logic                              push,
	output cdsc_pkg::cmd_t                    cmd,
	input  logic                              q_full
);

	localparam int IN_YB = (YEAR_BITS < cdsc_pkg::YEAR_W) ? YEAR_BITS : cdsc_pkg::YEAR_W;
	localparam logic [cdsc_pkg::YEAR_W-1:0] YMASK =
		cdsc_pkg::YEAR_W'((32'd1 << IN_YB) - 32'd1);

	logic                        valid_s1;
	logic                        act_s1;
	cdsc_pkg::date_t             start_s1;
	cdsc_pkg::date_t             target_s1;
	logic [cdsc_pkg::DCNT_W-1:0] back_s1;
	logic                        sleap_s1;
	logic                        tleap_s1;

	cdsc_pkg::date_t             start_m;
	cdsc_pkg::date_t             target_m;
	logic                        start_ok;
	logic                        target_ok;
	logic                        swap;

	// years keep only the configured low bits
	always_comb begin
		start_m       = start_date;
		start_m.year  = start_date.year & YMASK;
		target_m      = target_date;
		target_m.year = target_date.year & YMASK;
	end

	assign in_ready = !valid_s1 || !q_full;
	assign push     = valid_s1 && !q_full;

	// stage 1: capture the transaction and the leap flags of both years
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			act_s1    <= action;
			start_s1  <= start_m;
			target_s1 <= target_m;
			back_s1   <= days_back;
			sleap_s1  <= cdsc_pkg::is_leap(start_m.year);
			tleap_s1  <= cdsc_pkg::is_leap(target_m.year);
		end
	end

	// stage 2: check dates and put the dates of a difference request in order
	always_comb begin
		start_ok  = (start_s1.month inside {[cdsc_pkg::MON_JAN:cdsc_pkg::MON_DEC]})
			&& (start_s1.day != '0)
			&& (start_s1.day <= cdsc_pkg::month_len(start_s1.month, sleap_s1));
		target_ok = (target_s1.month inside {[cdsc_pkg::MON_JAN:cdsc_pkg::MON_DEC]})
			&& (target_s1.day != '0)
			&& (target_s1.day <= cdsc_pkg::month_len(target_s1.month, tleap_s1));
		swap      = (act_s1 == cdsc_pkg::ACT_DIFF) && (start_s1 > target_s1);

		cmd.act       = act_s1;
		cmd.bad       = !start_ok || ((act_s1 == cdsc_pkg::ACT_DIFF) && !target_ok);
		cmd.first     = swap ? target_s1 : start_s1;
		cmd.last      = swap ? start_s1 : target_s1;
		cmd.days_back = back_s1;
	end

endmodule

>>> hw/rtl/cdsc_queue.sv
module cdsc_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  cdsc_pkg::cmd_t push_data,
	output logic           full,
	input  logic           pop,
	output cdsc_pkg::cmd_t pop_data,
	output logic           empty
);

	cdsc_pkg::cmd_t mem_q [2];
	logic           wptr_q;
	logic           rptr_q;
	logic [1:0]     count_q;

	assign full     = (count_q == 2'd2);
	assign empty    = (count_q == 2'd0);
	assign pop_data = mem_q[rptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= !wptr_q;
			end
			if (pop) begin
				rptr_q <= !rptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_data;
		end
	end

endmodule

>>> hw/rtl/cdsc_back.sv
module cdsc_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	input  cdsc_pkg::cmd_t    q_data,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output cdsc_pkg::result_t out_data
);

	cdsc_pkg::back_state_t       state_q;
	cdsc_pkg::back_state_t       state_d;

	logic                        act_q;
	logic                        bad_q;
	cdsc_pkg::date_t             cur_q;
	cdsc_pkg::date_t             end_q;
	logic [cdsc_pkg::DCNT_W-1:0] rem_q;
	logic [cdsc_pkg::DCNT_W-1:0] dcnt_q;
	logic [cdsc_pkg::MCNT_W-1:0] mcnt_q;
	logic [cdsc_pkg::YCNT_W-1:0] ycnt_q;
	logic                        uflow_q;
	logic                        out_valid_q;
	cdsc_pkg::result_t           out_q;

	logic                        leap;
	logic [cdsc_pkg::DAY_W-1:0]  mlen;
	logic [cdsc_pkg::DAY_W-1:0]  plen;
	logic [cdsc_pkg::MONTH_W-1:0] prev_mon;
	logic                        at_mend;
	logic                        at_yend;
	logic                        at_end;
	logic                        at_origin;
	logic                        rem_zero;
	logic                        run_done;
	cdsc_pkg::date_t             fwd;
	cdsc_pkg::date_t             bwd;
	logic                        slot_free;
	logic                        out_load;
	cdsc_pkg::result_t           res;

	// one calendar day forward or back per cycle
	always_comb begin
		leap      = cdsc_pkg::is_leap(cur_q.year);
		mlen      = cdsc_pkg::month_len(cur_q.month, leap);
		at_mend   = (cur_q.day == mlen);
		at_yend   = at_mend && (cur_q.month == cdsc_pkg::MON_DEC);

		fwd.day   = at_mend ? cdsc_pkg::DAY_ONE : cur_q.day + 5'd1;
		fwd.month = !at_mend ? cur_q.month
			: (at_yend ? cdsc_pkg::MON_JAN : cur_q.month + 4'd1);
		fwd.year  = at_yend ? cur_q.year + 14'd1 : cur_q.year;

		prev_mon  = (cur_q.month == cdsc_pkg::MON_JAN) ? cdsc_pkg::MON_DEC
			: cur_q.month - 4'd1;
		plen      = cdsc_pkg::month_len(prev_mon, leap);
		bwd.day   = (cur_q.day == cdsc_pkg::DAY_ONE) ? plen : cur_q.day - 5'd1;
		bwd.month = (cur_q.day == cdsc_pkg::DAY_ONE) ? prev_mon : cur_q.month;
		bwd.year  = ((cur_q.day == cdsc_pkg::DAY_ONE) && (cur_q.month == cdsc_pkg::MON_JAN))
			? cur_q.year - 14'd1 : cur_q.year;

		at_end    = (cur_q == end_q);
		at_origin = (cur_q.day == cdsc_pkg::DAY_ONE) && (cur_q.month == cdsc_pkg::MON_JAN)
			&& (cur_q.year == '0);
		rem_zero  = (rem_q == '0);
		run_done  = (act_q == cdsc_pkg::ACT_SUB) ? (rem_zero || at_origin) : at_end;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			cdsc_pkg::BK_IDLE: begin
				if (!q_empty) begin
					state_d = q_data.bad ? cdsc_pkg::BK_DONE : cdsc_pkg::BK_RUN;
				end
			end
			cdsc_pkg::BK_RUN: begin
				if (run_done) begin
					state_d = cdsc_pkg::BK_DONE;
				end
			end
			cdsc_pkg::BK_DONE: begin
				if (slot_free) begin
					state_d = cdsc_pkg::BK_IDLE;
				end
			end
			default: state_d = cdsc_pkg::BK_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		pop      = 1'b0;
		out_load = 1'b0;
		case (state_q)
			cdsc_pkg::BK_IDLE: pop      = !q_empty;
			cdsc_pkg::BK_DONE: out_load = slot_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cdsc_pkg::BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (pop) begin
			act_q   <= q_data.act;
			bad_q   <= q_data.bad;
			cur_q   <= q_data.first;
			end_q   <= q_data.last;
			rem_q   <= q_data.days_back;
			dcnt_q  <= '0;
			mcnt_q  <= '0;
			ycnt_q  <= '0;
			uflow_q <= 1'b0;
		end else if ((state_q == cdsc_pkg::BK_RUN) && !run_done) begin
			if (act_q == cdsc_pkg::ACT_SUB) begin
				cur_q <= bwd;
				rem_q <= rem_q - 22'd1;
			end else begin
				cur_q <= fwd;
				if (dcnt_q != '1) begin
					dcnt_q <= dcnt_q + 22'd1;
				end
				if (at_mend && (mcnt_q != '1)) begin
					mcnt_q <= mcnt_q + 17'd1;
				end
				if (at_yend && (ycnt_q != '1)) begin
					ycnt_q <= ycnt_q + 14'd1;
				end
			end
		end else if ((state_q == cdsc_pkg::BK_RUN) && (act_q == cdsc_pkg::ACT_SUB)
				&& !rem_zero) begin
			uflow_q <= 1'b1;
		end
	end

	// result assembly
	always_comb begin
		res                 = '0;
		res.bad_date        = bad_q;
		if (!bad_q) begin
			if (act_q == cdsc_pkg::ACT_SUB) begin
				res.result_day   = cur_q.day;
				res.result_month = cur_q.month;
				res.result_year  = cur_q.year;
				res.underflow    = uflow_q;
			end else begin
				res.day_count       = dcnt_q;
				res.month_crossings = mcnt_q;
				res.year_crossings  = ycnt_q;
			end
		end
	end

	// output register, frees the stepper while a result waits
	assign slot_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (slot_free) begin
			out_valid_q <= out_load;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

>>> hw/rtl/calendar_day_step_counter.sv
// Gregorian date engine. Each input transaction is either a difference request
// (tuser 0: days, month boundaries and year boundaries between start and target,
// in either order) or a subtract request (tuser 1: start date moved back by
// days_back, clamped at 1-1-0 with underflow). Invalid dates give bad_date and
// zero results. Only the low YEAR_BITS bits of the year fields are used. The
// stepper walks one calendar day per clock over the span in days (difference)
// or over days_back (subtract, fewer if it stops at 1-1-0); bad dates skip the
// stepping and go straight to the result. A two-deep request
// queue sits in front of the stepper and a result register behind it, so new
// requests are taken while one is stepping or its result waits.
module calendar_day_step_counter #(
	parameter int YEAR_BITS = 14
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// start_day, start_month, start_year, target_day, target_month,
	// target_year, days_back, zero pad
	input  logic [71:0] s_axis_tdata,
	// action
	input  logic        s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// day_count, month_crossings, year_crossings, result_day, result_month,
	// result_year, zero pad
	output logic [79:0] m_axis_tdata,
	// underflow, bad_date
	output logic [1:0]  m_axis_tuser
);

	cdsc_pkg::date_t   start_date;
	cdsc_pkg::date_t   target_date;
	logic              push;
	logic              q_full;
	logic              q_empty;
	logic              pop;
	cdsc_pkg::cmd_t    push_cmd;
	cdsc_pkg::cmd_t    pop_cmd;
	cdsc_pkg::result_t res;

	// unpack the request
	always_comb begin
		start_date.day    = s_axis_tdata[4:0];
		start_date.month  = s_axis_tdata[8:5];
		start_date.year   = s_axis_tdata[22:9];
		target_date.day   = s_axis_tdata[27:23];
		target_date.month = s_axis_tdata[31:28];
		target_date.year  = s_axis_tdata[45:32];
	end

	cdsc_front #(
		.YEAR_BITS(YEAR_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.action     (s_axis_tuser),
		.start_date (start_date),
		.target_date(target_date),
		.days_back  (s_axis_tdata[67:46]),
		.push       (push),
		.cmd        (push_cmd),
		.q_full     (q_full)
	);

	cdsc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_cmd),
		.full     (q_full),
		.pop      (pop),
		.pop_data (pop_cmd),
		.empty    (q_empty)
	);

	cdsc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_data   (pop_cmd),
		.pop      (pop),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_data (res)
	);

	// pack the result
	assign m_axis_tdata = {4'd0, res.result_year, res.result_month, res.result_day,
		res.year_crossings, res.month_crossings, res.day_count};
	assign m_axis_tuser = {res.bad_date, res.underflow};

`ifndef NO_ASSERTIONS
	// a bad date carries nothing else
	a_bad_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[1]) |-> (m_axis_tdata == '0) && !m_axis_tuser[0])
		else $error("bad_date result with nonzero fields");

	// underflow clamps to the first day of year 0
	a_uflow_origin: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[0]) |-> (res.result_day == cdsc_pkg::DAY_ONE)
			&& (res.result_month == cdsc_pkg::MON_JAN) && (res.result_year == '0))
		else $error("underflow result is not 1-1-0");

	// a subtract result never carries difference counts
	a_modes_apart: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (res.result_month != '0)) |-> (res.day_count == '0)
			&& (res.month_crossings == '0) && (res.year_crossings == '0))
		else $error("result date and counts both set");
`endif

endmodule
